[src/barycentric_height_interp_unit_macros.svh]
// ============================================================================
// barycentric_height_interp_unit_macros.svh
// Assertion shorthands for the barycentric height interpolation unit.
// ============================================================================
`ifndef BARYCENTRIC_HEIGHT_INTERP_UNIT_MACROS_SVH
`define BARYCENTRIC_HEIGHT_INTERP_UNIT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define BHI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked only out of reset.
`define BHI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bhi_pkg.sv]
// ============================================================================
// bhi_pkg
// Widths, field positions and pipeline stage types of the barycentric
// height interpolation unit.
// ============================================================================
package bhi_pkg;

   // Field geometry
   localparam int COORD_W    = 32;
   localparam int REQ_FIELDS = 11;
   localparam int REQ_DATA_W = REQ_FIELDS * COORD_W;
   localparam int RSP_DATA_W = COORD_W;
   localparam int RSP_USER_W = 2;

   // Request field positions inside req_tdata, in units of COORD_W
   localparam int F_AX = 0;
   localparam int F_AH = 1;
   localparam int F_AZ = 2;
   localparam int F_BX = 3;
   localparam int F_BH = 4;
   localparam int F_BZ = 5;
   localparam int F_CX = 6;
   localparam int F_CH = 7;
   localparam int F_CZ = 8;
   localparam int F_QX = 9;
   localparam int F_QZ = 10;

   // Response flag positions inside rsp_tuser
   localparam int USER_DEGEN = 0;
   localparam int USER_SAT   = 1;

   // Arithmetic widths (all exact)
   localparam int DIFF_W    = COORD_W + 1;           // coordinate difference
   localparam int PROD_W    = 2 * DIFF_W;            // difference product
   localparam int NUM_W     = PROD_W + 1;            // det, n1, n2
   localparam int SLICE_W   = 23;                    // weight slice per multiplier
   localparam int SLICE_CNT = 3;
   localparam int WGT_W     = SLICE_W * SLICE_CNT;   // n1, n2, n3
   localparam int WGT_CNT   = 3;
   localparam int PP_W      = SLICE_W + 1 + COORD_W; // slice times height
   localparam int SUM_W     = 104;                   // weighted height sum
   localparam int MAG_W     = SUM_W - 1;             // |sum|
   localparam int DEN_W     = NUM_W - 1;             // |det|
   localparam int QUO_W     = COORD_W;               // quotient bits

   // Pipeline depth: eight front stages, overflow stage, one per quotient bit
   localparam int FRONT_STAGES = 8;
   localparam int PIPE_STAGES  = FRONT_STAGES + QUO_W + 1;

   localparam logic [COORD_W-1:0] HEIGHT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] HEIGHT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [DIFF_W-1:0]  diff_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [NUM_W-1:0]   num_type;
   typedef logic [WGT_W-1:0]   wgt_type;
   typedef logic [PP_W-1:0]    pp_type;
   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [MAG_W-1:0]   mag_type;
   typedef logic [DEN_W-1:0]   den_type;
   typedef logic [QUO_W-1:0]   quo_type;

   // Stage 1: coordinate differences
   typedef struct packed {
      diff_type                  dbz;
      diff_type                  dcbx;
      diff_type                  dacx;
      diff_type                  dacz;
      diff_type                  dcaz;
      diff_type                  dqx;
      diff_type                  dqz;
      coord_type [WGT_CNT-1:0]   hgt;
   } s1_type;

   // Stage 2: difference products
   typedef struct packed {
      prod_type                  pd0;
      prod_type                  pd1;
      prod_type                  pa0;
      prod_type                  pa1;
      prod_type                  pb0;
      prod_type                  pb1;
      coord_type [WGT_CNT-1:0]   hgt;
   } s2_type;

   // Stage 3: det and the two weight numerators
   typedef struct packed {
      num_type                   det;
      num_type                   n1;
      num_type                   n2;
      coord_type [WGT_CNT-1:0]   hgt;
   } s3_type;

   // Stage 4: all three weights
   typedef struct packed {
      wgt_type [WGT_CNT-1:0]     wgt;
      num_type                   det;
      logic                      degen;
      coord_type [WGT_CNT-1:0]   hgt;
   } s4_type;

   // Stage 5: partial products of weight slices and heights
   typedef struct packed {
      pp_type [WGT_CNT*SLICE_CNT-1:0] pp;
      num_type                        det;
      logic                           degen;
   } s5_type;

   // Stage 6: one weighted height per vertex
   typedef struct packed {
      sum_type [WGT_CNT-1:0]     ws;
      num_type                   det;
      logic                      degen;
   } s6_type;

   // Stage 7: weighted height sum
   typedef struct packed {
      sum_type                   sum;
      num_type                   det;
      logic                      degen;
   } s7_type;

   // Stage 8: magnitudes and quotient sign
   typedef struct packed {
      mag_type                   nm;
      den_type                   dm;
      logic                      neg;
      logic                      degen;
   } s8_type;

   // Divider stages: partial remainder and quotient so far
   typedef struct packed {
      mag_type                   rem;
      den_type                   dm;
      quo_type                   quo;
      logic                      ovf;
      logic                      neg;
      logic                      degen;
   } div_type;

   typedef struct packed {
      logic                      saturated;
      logic                      degenerate;
   } rsp_flags_type;

   typedef struct packed {
      rsp_flags_type             flags;
      coord_type                 height;
   } rsp_type;

endpackage

[src/barycentric_height_interp_unit.sv]
// ============================================================================
// barycentric_height_interp_unit
// Height of a query point over a triangle by exact barycentric weights,
// one division by det, truncated and saturated to signed Q16.16.
// ============================================================================
// Usage:
//   A request carries three vertices (x, height, z) and a query point (x, z),
//   all signed Q16.16, on req_tdata. Each request gives exactly one response
//   on rsp_tdata (height) with rsp_tuser flags degenerate and saturated.
//   Both channels complete a transfer when tvalid and tready are high.
//   The pipeline takes one request every cycle while the skid register is
//   empty. The depth is set by the divider, which resolves one quotient
//   bit per stage over 32 stages, behind eight stages of differences,
//   products, weights, weighted sums and magnitudes.
//   Reset empties the pipeline and the output registers; no response is
//   pending afterwards.
//   When the receiver stalls, the output register holds its response and a
//   skid register catches the next one; once the skid register is full the
//   whole pipeline freezes and req_tready drops. Nothing is dropped or sent
//   twice. req_tready depends only on registered state.
// ============================================================================
`include "barycentric_height_interp_unit_macros.svh"

module barycentric_height_interp_unit (
   input  logic                             clock,
   input  logic                             reset,
   // a_x, a_height, a_z, b_x, b_height, b_z, c_x, c_height, c_z, query_x, query_z
   input  logic [bhi_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // height
   output logic [bhi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // degenerate, saturated
   output logic [bhi_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);
   import bhi_pkg::*;

   logic                    adv;
   logic                    incoming;
   logic [PIPE_STAGES-1:0]  pipe_vld_ff, pipe_vld_in;

   coord_type               fld [REQ_FIELDS];

   s1_type                  s1_ff, s1_in;
   s2_type                  s2_ff, s2_in;
   s3_type                  s3_ff, s3_in;
   s4_type                  s4_ff, s4_in;
   s5_type                  s5_ff, s5_in;
   s6_type                  s6_ff, s6_in;
   s7_type                  s7_ff, s7_in;
   s8_type                  s8_ff, s8_in;
   div_type                 div_ff [QUO_W+1];
   div_type                 div_in [QUO_W+1];

   rsp_type                 fmt;
   rsp_type                 out_ff, out_in;
   rsp_type                 skid_ff, skid_in;
   logic                    out_vld_ff, out_vld_in;
   logic                    skid_vld_ff, skid_vld_in;

   // Pipeline moves as one while the skid register is free
   assign adv        = !skid_vld_ff;
   assign req_tready = adv;
   assign incoming   = adv && pipe_vld_ff[PIPE_STAGES-1];

   assign pipe_vld_in = adv ? {pipe_vld_ff[PIPE_STAGES-2:0], req_tvalid} : pipe_vld_ff;

   // Unpack request fields
   always_comb begin
      for (int i = 0; i < REQ_FIELDS; i++) begin
         fld[i] = req_tdata[i*COORD_W +: COORD_W];
      end
   end

   // Stage 1: coordinate differences on the x-z plane
   always_comb begin
      s1_in.dbz    = DIFF_W'($signed(fld[F_BZ])) - DIFF_W'($signed(fld[F_CZ]));
      s1_in.dcbx   = DIFF_W'($signed(fld[F_CX])) - DIFF_W'($signed(fld[F_BX]));
      s1_in.dacx   = DIFF_W'($signed(fld[F_AX])) - DIFF_W'($signed(fld[F_CX]));
      s1_in.dacz   = DIFF_W'($signed(fld[F_AZ])) - DIFF_W'($signed(fld[F_CZ]));
      s1_in.dcaz   = DIFF_W'($signed(fld[F_CZ])) - DIFF_W'($signed(fld[F_AZ]));
      s1_in.dqx    = DIFF_W'($signed(fld[F_QX])) - DIFF_W'($signed(fld[F_CX]));
      s1_in.dqz    = DIFF_W'($signed(fld[F_QZ])) - DIFF_W'($signed(fld[F_CZ]));
      s1_in.hgt[0] = fld[F_AH];
      s1_in.hgt[1] = fld[F_BH];
      s1_in.hgt[2] = fld[F_CH];
   end

   // Stage 2: six 33x33 products
   always_comb begin
      s2_in.pd0 = PROD_W'($signed(s1_ff.dbz))  * PROD_W'($signed(s1_ff.dacx));
      s2_in.pd1 = PROD_W'($signed(s1_ff.dcbx)) * PROD_W'($signed(s1_ff.dacz));
      s2_in.pa0 = PROD_W'($signed(s1_ff.dbz))  * PROD_W'($signed(s1_ff.dqx));
      s2_in.pa1 = PROD_W'($signed(s1_ff.dcbx)) * PROD_W'($signed(s1_ff.dqz));
      s2_in.pb0 = PROD_W'($signed(s1_ff.dcaz)) * PROD_W'($signed(s1_ff.dqx));
      s2_in.pb1 = PROD_W'($signed(s1_ff.dacx)) * PROD_W'($signed(s1_ff.dqz));
      s2_in.hgt = s1_ff.hgt;
   end

   // Stage 3: det, n1, n2
   always_comb begin
      s3_in.det = NUM_W'($signed(s2_ff.pd0)) + NUM_W'($signed(s2_ff.pd1));
      s3_in.n1  = NUM_W'($signed(s2_ff.pa0)) + NUM_W'($signed(s2_ff.pa1));
      s3_in.n2  = NUM_W'($signed(s2_ff.pb0)) + NUM_W'($signed(s2_ff.pb1));
      s3_in.hgt = s2_ff.hgt;
   end

   // Stage 4: third weight so the weights sum to det exactly
   always_comb begin
      s4_in.wgt[0] = WGT_W'($signed(s3_ff.n1));
      s4_in.wgt[1] = WGT_W'($signed(s3_ff.n2));
      s4_in.wgt[2] = WGT_W'($signed(s3_ff.det)) - WGT_W'($signed(s3_ff.n1))
                   - WGT_W'($signed(s3_ff.n2));
      s4_in.det    = s3_ff.det;
      s4_in.degen  = (s3_ff.det == '0);
      s4_in.hgt    = s3_ff.hgt;
   end

   // Stage 5: weight slices times heights; top slice signed, others unsigned
   always_comb begin
      logic [SLICE_W-1:0] slc;
      logic               ext;
      s5_in.det   = s4_ff.det;
      s5_in.degen = s4_ff.degen;
      for (int k = 0; k < WGT_CNT; k++) begin
         for (int s = 0; s < SLICE_CNT; s++) begin
            slc = s4_ff.wgt[k][s*SLICE_W +: SLICE_W];
            ext = (s == SLICE_CNT-1) ? slc[SLICE_W-1] : 1'b0;
            s5_in.pp[k*SLICE_CNT+s] = PP_W'($signed({ext, slc}))
                                    * PP_W'($signed(s4_ff.hgt[k]));
         end
      end
   end

   // Stage 6: reassemble each weighted height from its slices
   always_comb begin
      sum_type acc;
      s6_in.det   = s5_ff.det;
      s6_in.degen = s5_ff.degen;
      for (int k = 0; k < WGT_CNT; k++) begin
         acc = '0;
         for (int s = 0; s < SLICE_CNT; s++) begin
            acc = acc + (SUM_W'($signed(s5_ff.pp[k*SLICE_CNT+s])) << (s*SLICE_W));
         end
         s6_in.ws[k] = acc;
      end
   end

   // Stage 7: weighted height sum
   always_comb begin
      s7_in.sum   = s6_ff.ws[0] + s6_ff.ws[1] + s6_ff.ws[2];
      s7_in.det   = s6_ff.det;
      s7_in.degen = s6_ff.degen;
   end

   // Stage 8: magnitudes and sign of the quotient
   always_comb begin
      s8_in.nm    = s7_ff.sum[SUM_W-1] ? MAG_W'(SUM_W'(0) - s7_ff.sum) : MAG_W'(s7_ff.sum);
      s8_in.dm    = s7_ff.det[NUM_W-1] ? DEN_W'(NUM_W'(0) - s7_ff.det) : DEN_W'(s7_ff.det);
      s8_in.neg   = s7_ff.sum[SUM_W-1] ^ s7_ff.det[NUM_W-1];
      s8_in.degen = s7_ff.degen;
   end

   // Divider entry: a quotient of 2^32 or more always saturates
   always_comb begin
      div_in[0].rem   = s8_ff.nm;
      div_in[0].dm    = s8_ff.dm;
      div_in[0].quo   = '0;
      div_in[0].ovf   = (s8_ff.nm >= (MAG_W'(s8_ff.dm) << QUO_W));
      div_in[0].neg   = s8_ff.neg;
      div_in[0].degen = s8_ff.degen;
   end

   // Restoring divider, one quotient bit per stage, most significant first
   for (genvar i = 1; i <= QUO_W; i++) begin : g_div
      mag_type dsh;
      assign dsh = MAG_W'(div_ff[i-1].dm) << (QUO_W - i);

      always_comb begin
         div_in[i] = div_ff[i-1];
         if (div_ff[i-1].rem >= dsh) begin
            div_in[i].rem            = div_ff[i-1].rem - dsh;
            div_in[i].quo[QUO_W - i] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[i] <= div_in[i];
         end
      end
   end

   // Payload registers of the front stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         s3_ff     <= s3_in;
         s4_ff     <= s4_in;
         s5_ff     <= s5_in;
         s6_ff     <= s6_in;
         s7_ff     <= s7_in;
         s8_ff     <= s8_in;
         div_ff[0] <= div_in[0];
      end
   end

   // Sign, saturation and the degenerate case
   always_comb begin
      div_type dl;
      dl                   = div_ff[QUO_W];
      fmt.flags.degenerate = dl.degen;
      fmt.flags.saturated  = 1'b0;
      fmt.height           = dl.quo;
      if (dl.degen) begin
         fmt.height = '0;
      end else if (dl.neg) begin
         if (dl.ovf || (dl.quo > HEIGHT_MIN)) begin
            fmt.height          = HEIGHT_MIN;
            fmt.flags.saturated = 1'b1;
         end else begin
            fmt.height = COORD_W'(0) - dl.quo;
         end
      end else begin
         if (dl.ovf || dl.quo[QUO_W-1]) begin
            fmt.height          = HEIGHT_MAX;
            fmt.flags.saturated = 1'b1;
         end
      end
   end

   // Output register with skid register behind it
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (rsp_tready) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!out_vld_ff || rsp_tready) begin
         out_vld_in = incoming;
         out_in     = fmt;
      end else if (incoming) begin
         skid_vld_in = 1'b1;
         skid_in     = fmt;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         pipe_vld_ff <= pipe_vld_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff.height;
   assign rsp_tuser  = out_ff.flags;

   // Checks
   `BHI_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_vld_ff, out_vld_ff, "skid full with output register empty")
   `BHI_ASSERT_NEXT(a_skid_drains, clock, reset, skid_vld_ff && rsp_tready, !skid_vld_ff, "skid register did not drain")
   `BHI_ASSERT_NOW(a_div_rem, clock, reset, pipe_vld_ff[PIPE_STAGES-1] && !div_ff[QUO_W].ovf && !div_ff[QUO_W].degen, div_ff[QUO_W].rem < MAG_W'(div_ff[QUO_W].dm), "final remainder not below divisor")
   `BHI_ASSERT_NOW(a_degen_zero, clock, reset, rsp_tvalid && rsp_tuser[USER_DEGEN], (rsp_tdata == '0) && !rsp_tuser[USER_SAT], "degenerate response not zero")
   `BHI_ASSERT_NOW(a_sat_clamp, clock, reset, rsp_tvalid && rsp_tuser[USER_SAT], (rsp_tdata == HEIGHT_MAX) || (rsp_tdata == HEIGHT_MIN), "saturated response not at a limit")

endmodule
